FILE: src/smt_pkg.sv
// Shared types, codes and sizes for the sorted multiset table.
package smt_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int REMOVED_W     = 5;

    // Action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] entry_value;
        logic [REMOVED_W-1:0]      removed_count;
        logic [1:0]                status;
        logic                      last;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       load_ins;
        logic       rd;
        logic       rd_prev;
        logic       ins_put;
        logic       ins_shift;
        logic       rem_step;
        logic       rem_fin;
        logic       adv;
        logic       clr;
        logic       res_en;
        logic       res_entry;
        logic       res_removed;
        logic       res_last;
        logic [1:0] res_status;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic idx_zero;
        logic idx_end;
        logic place;
        logic rd_last;
        logic none_removed;
    } t_dp_sts;

endpackage

FILE: src/sorted_multiset_table.sv
// Top level of the sorted multiset table: controller plus datapath.
//
//  channel   handshake              payload                 direction
//  command   start / busy           i_item (action, value)  in
//  result    o_strobe, one cycle    o_result                out
//
// An item is taken when start is high and busy is low. Every result is a
// single-cycle strobe in the cycle after the step that forms it; the receiver
// cannot stall. Entries sit in a single-port memory with registered read,
// so each entry visited takes an address step, then a compare/move step.
// Busy stays high while insert walks down moving entries up a slot, while
// readout or remove walks through every entry, and while clear, full insert,
// empty readout or empty remove is dispatched.
// Synchronous reset empties the table at once; entry contents are kept.
module sorted_multiset_table #(
    parameter int DEPTH = smt_pkg::DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  smt_pkg::t_in  i_item,
    output logic          busy,
    output logic          o_strobe,
    output smt_pkg::t_out o_result
);
    import smt_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    smt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_item.action),
        .i_sts    (dp_sts),
        .busy     (busy),
        .o_cmd    (dp_cmd)
    );

    smt_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_value  (i_item.value),
        .o_sts    (dp_sts),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

FILE: src/smt_ctrl.sv
// Controller state machine sequencing insert, readout, remove and clear.
module smt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [1:0]        i_action,
    input  smt_pkg::t_dp_sts  i_sts,
    output logic              busy,
    output smt_pkg::t_dp_cmd  o_cmd
);
    import smt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DISP = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_EVAL = 2'd3;

    logic [1:0] r_state, n_state;
    logic [1:0] r_op, n_op;
    t_dp_cmd    cmd;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    cmd.load     = 1'b1;
                    cmd.load_ins = (i_action == ACT_INSERT);
                    n_op         = i_action;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                unique case (r_op) inside
                    ACT_INSERT: begin
                        if (i_sts.full) begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = ST_FULL;
                            cmd.res_last   = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    ACT_READ, ACT_REMOVE: begin
                        if (i_sts.empty) begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = ST_EMPTY;
                            cmd.res_last   = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    ACT_CLEAR: begin
                        cmd.clr        = 1'b1;
                        cmd.res_en     = 1'b1;
                        cmd.res_status = i_sts.empty ? ST_EMPTY : ST_OK;
                        cmd.res_last   = 1'b1;
                        n_state        = S_IDLE;
                    end
                endcase
            end
            S_RD: begin
                unique case (r_op) inside
                    ACT_INSERT: begin
                        if (i_sts.idx_zero) begin
                            // reached the bottom: value goes in slot zero
                            cmd.ins_put    = 1'b1;
                            cmd.res_en     = 1'b1;
                            cmd.res_status = ST_OK;
                            cmd.res_last   = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            cmd.rd      = 1'b1;
                            cmd.rd_prev = 1'b1;
                            n_state     = S_EVAL;
                        end
                    end
                    ACT_REMOVE: begin
                        if (i_sts.idx_end) begin
                            cmd.rem_fin     = 1'b1;
                            cmd.res_en      = 1'b1;
                            cmd.res_removed = 1'b1;
                            cmd.res_status  = i_sts.none_removed ? ST_NOTFOUND : ST_OK;
                            cmd.res_last    = 1'b1;
                            n_state         = S_IDLE;
                        end else begin
                            cmd.rd  = 1'b1;
                            n_state = S_EVAL;
                        end
                    end
                    ACT_READ, ACT_CLEAR: begin
                        cmd.rd  = 1'b1;
                        n_state = S_EVAL;
                    end
                endcase
            end
            S_EVAL: begin
                unique case (r_op) inside
                    ACT_INSERT: begin
                        if (i_sts.place) begin
                            cmd.ins_put    = 1'b1;
                            cmd.res_en     = 1'b1;
                            cmd.res_status = ST_OK;
                            cmd.res_last   = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            // move the entry up one slot and keep walking down
                            cmd.ins_shift = 1'b1;
                            n_state       = S_RD;
                        end
                    end
                    ACT_REMOVE: begin
                        cmd.rem_step = 1'b1;
                        n_state      = S_RD;
                    end
                    ACT_READ: begin
                        cmd.res_en     = 1'b1;
                        cmd.res_entry  = 1'b1;
                        cmd.res_status = ST_OK;
                        cmd.res_last   = i_sts.rd_last;
                        cmd.adv        = 1'b1;
                        n_state        = i_sts.rd_last ? S_IDLE : S_RD;
                    end
                    ACT_CLEAR: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= ACT_INSERT;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign busy  = (r_state != S_IDLE);
    assign o_cmd = cmd;

    a_start_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_DISP))
        else $error("accepted transaction did not reach dispatch");

endmodule

FILE: src/smt_dp.sv
// Datapath: entry memory, fill count, scan pointers and result register.
module smt_dp #(
    parameter int DEPTH = smt_pkg::DEPTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  smt_pkg::t_dp_cmd                   i_cmd,
    input  logic signed [smt_pkg::VALUE_W-1:0] i_value,
    output smt_pkg::t_dp_sts                   o_sts,
    output logic                               o_strobe,
    output smt_pkg::t_out                      o_result
);
    import smt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rd_data;
    logic signed [VALUE_W-1:0] r_value;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_wr, n_wr;
    logic [CW-1:0] r_removed, n_removed;
    t_out          r_res, n_res;
    logic          r_res_vld;

    logic [CW-1:0]             idx_dec, idx_inc, rd_ptr, wr_ptr;
    logic [AW-1:0]             rd_addr, wr_addr;
    logic                      wr_en, match;
    logic signed [VALUE_W-1:0] wr_data;

    assign idx_dec = r_idx - CW'(1);
    assign idx_inc = r_idx + CW'(1);
    assign match   = (r_rd_data == r_value);

    assign rd_ptr  = i_cmd.rd_prev ? idx_dec : r_idx;
    assign rd_addr = rd_ptr[AW-1:0];
    assign wr_ptr  = i_cmd.rem_step ? r_wr : r_idx;
    assign wr_addr = wr_ptr[AW-1:0];
    assign wr_en   = i_cmd.ins_put | i_cmd.ins_shift | (i_cmd.rem_step & ~match);
    assign wr_data = i_cmd.ins_put ? r_value : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_wr      = r_wr;
        n_removed = r_removed;
        if (i_cmd.load) begin
            n_idx     = i_cmd.load_ins ? r_count : '0;
            n_wr      = '0;
            n_removed = '0;
        end
        if (i_cmd.ins_put) begin
            n_count = r_count + CW'(1);
        end
        if (i_cmd.ins_shift) begin
            n_idx = idx_dec;
        end
        if (i_cmd.rem_step) begin
            n_idx = idx_inc;
            if (match) begin
                n_removed = r_removed + CW'(1);
            end else begin
                n_wr = r_wr + CW'(1);
            end
        end
        if (i_cmd.adv) begin
            n_idx = idx_inc;
        end
        if (i_cmd.rem_fin) begin
            n_count = r_wr;
        end
        if (i_cmd.clr) begin
            n_count = '0;
        end
    end

    always_comb begin
        n_res.entry_value   = i_cmd.res_entry ? r_rd_data : '0;
        n_res.removed_count = i_cmd.res_removed ? REMOVED_W'(r_removed) : '0;
        n_res.status        = i_cmd.res_status;
        n_res.last          = i_cmd.res_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_wr      <= '0;
            r_removed <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_wr      <= n_wr;
            r_removed <= n_removed;
            r_res_vld <= i_cmd.res_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
        end
        if (i_cmd.res_en) begin
            r_res <= n_res;
        end
    end

    assign o_sts.empty        = (r_count == '0);
    assign o_sts.full         = (r_count == CW'(DEPTH));
    assign o_sts.idx_zero     = (r_idx == '0);
    assign o_sts.idx_end      = (r_idx == r_count);
    assign o_sts.place        = (r_value > r_rd_data);
    assign o_sts.rd_last      = (idx_inc == r_count);
    assign o_sts.none_removed = (r_removed == '0);

    assign o_strobe = r_res_vld;
    assign o_result = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond table depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_put |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the table by one");

    a_compact_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr <= r_idx)
        else $error("compaction pointer overtook the scan pointer");

    a_status_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.status != ST_OK) |-> (r_res.last && r_res.entry_value == '0))
        else $error("non-ok result not final or carries an entry");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the sorted multiset table.
`timescale 1ns / 1ps

module tb;

    import smt_pkg::*;

    localparam int DEPTH      = DEPTH_DEFAULT;
    localparam int DRAIN_WAIT = 3 + 2 * DEPTH + 8;
    localparam int SHOW_MAX   = 10;

    typedef struct {
        logic [1:0]          action;
        logic signed [31:0]  value;
        int                  reps;
        bit                  typed;
        t_out                result;
    } t_dir_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    t_in   i_item;
    logic  busy;
    logic  o_strobe;
    t_out  o_result;

    sorted_multiset_table #(
        .DEPTH (DEPTH)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    logic signed [31:0] shadow_entries[$];
    t_out               predicted[$];
    t_out               pending_results[$];
    t_out               want;
    int                 mismatch_count = 0;
    int                 idle_pct = 0;
    bit                 row_typed = 1'b0;
    t_out               row_result = '0;
    logic signed [31:0] value_pool[6];

    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    // Apply one transaction to the shadow table and list the results it causes.
    function automatic void predict_table_op(input t_in it);
        int                 pos;
        logic [4:0]         gone;
        logic signed [31:0] kept[$];
        t_out               r;
        predicted.delete();
        r      = '0;
        r.last = 1'b1;
        case (it.action)
            ACT_INSERT: begin
                if (shadow_entries.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < shadow_entries.size() && it.value > shadow_entries[pos])
                        pos++;
                    shadow_entries.insert(pos, it.value);
                    r.status = ST_OK;
                end
                predicted.push_back(r);
            end
            ACT_READ: begin
                if (shadow_entries.size() == 0) begin
                    r.status = ST_EMPTY;
                    predicted.push_back(r);
                end else begin
                    foreach (shadow_entries[k]) begin
                        r.entry_value = shadow_entries[k];
                        r.status      = ST_OK;
                        r.last        = (k == shadow_entries.size() - 1);
                        predicted.push_back(r);
                    end
                end
            end
            ACT_REMOVE: begin
                if (shadow_entries.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    gone = '0;
                    foreach (shadow_entries[k]) begin
                        if (shadow_entries[k] == it.value)
                            gone++;
                        else
                            kept.push_back(shadow_entries[k]);
                    end
                    shadow_entries  = kept;
                    r.removed_count = gone;
                    r.status        = (gone == 0) ? ST_NOTFOUND : ST_OK;
                end
                predicted.push_back(r);
            end
            ACT_CLEAR: begin
                r.status = (shadow_entries.size() == 0) ? ST_EMPTY : ST_OK;
                shadow_entries.delete();
                predicted.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(1) == 0)
            return value_pool[$urandom_range(5)];
        return $urandom;
    endfunction

    // Present one transaction, with random idle cycles first, and hold it until taken.
    task automatic issue(input t_in it, input bit typed, input t_out typed_res);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_item     <= it;
        row_typed  = typed;
        row_result = typed_res;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && busy === 1'b0) begin
                predict_table_op(i_item);
                if (row_typed)
                    pending_results.push_back(row_result);
                else
                    foreach (predicted[k]) pending_results.push_back(predicted[k]);
            end
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_MAX)
                        $display("%0t: unexpected result %p", $realtime, o_result);
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.entry_value !== want.entry_value
                            || o_result.removed_count !== want.removed_count
                            || o_result.status !== want.status
                            || o_result.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOW_MAX) begin
                            $display("%0t: mismatch exp value=%0d removed=%0d status=%0d last=%0b",
                                     $realtime, want.entry_value, want.removed_count,
                                     want.status, want.last);
                            $display("%0t:          got value=%0d removed=%0d status=%0d last=%0b",
                                     $realtime, o_result.entry_value,
                                     o_result.removed_count, o_result.status, o_result.last);
                        end
                    end
                end
            end
        end
    end

    initial begin
        t_dir_row dir_rows[21];
        t_in      it;
        int       issued;
        int       sel;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        dir_rows = '{
            '{ACT_READ,   32'sd0,         1,  1'b1, '{32'sd0, 5'd0,  ST_EMPTY,    1'b1}},
            '{ACT_REMOVE, 32'sd5,         1,  1'b1, '{32'sd0, 5'd0,  ST_EMPTY,    1'b1}},
            '{ACT_CLEAR,  32'sd0,         1,  1'b1, '{32'sd0, 5'd0,  ST_EMPTY,    1'b1}},
            '{ACT_INSERT, 32'h7fffffff,   1,  1'b1, '{32'sd0, 5'd0,  ST_OK,       1'b1}},
            '{ACT_INSERT, 32'h80000000,   1,  1'b1, '{32'sd0, 5'd0,  ST_OK,       1'b1}},
            '{ACT_INSERT, 32'sd0,         1,  1'b1, '{32'sd0, 5'd0,  ST_OK,       1'b1}},
            '{ACT_INSERT, -32'sd1,        1,  1'b1, '{32'sd0, 5'd0,  ST_OK,       1'b1}},
            '{ACT_INSERT, 32'h80000000,   1,  1'b1, '{32'sd0, 5'd0,  ST_OK,       1'b1}},
            '{ACT_READ,   32'hffffffff,   1,  1'b0, '0},
            '{ACT_REMOVE, 32'sd1234,      1,  1'b1, '{32'sd0, 5'd0,  ST_NOTFOUND, 1'b1}},
            '{ACT_REMOVE, 32'h80000000,   1,  1'b1, '{32'sd0, 5'd2,  ST_OK,       1'b1}},
            '{ACT_READ,   32'sd0,         1,  1'b0, '0},
            '{ACT_CLEAR,  32'hffffffff,   1,  1'b1, '{32'sd0, 5'd0,  ST_OK,       1'b1}},
            '{ACT_INSERT, 32'sd7,         16, 1'b1, '{32'sd0, 5'd0,  ST_OK,       1'b1}},
            '{ACT_INSERT, 32'sd8,         1,  1'b1, '{32'sd0, 5'd0,  ST_FULL,     1'b1}},
            '{ACT_READ,   32'sd0,         1,  1'b0, '0},
            '{ACT_REMOVE, 32'sd7,         1,  1'b1, '{32'sd0, 5'd16, ST_OK,       1'b1}},
            '{ACT_INSERT, 32'h55555555,   1,  1'b1, '{32'sd0, 5'd0,  ST_OK,       1'b1}},
            '{ACT_INSERT, 32'haaaaaaaa,   1,  1'b1, '{32'sd0, 5'd0,  ST_OK,       1'b1}},
            '{ACT_REMOVE, -32'sd1,        1,  1'b1, '{32'sd0, 5'd0,  ST_NOTFOUND, 1'b1}},
            '{ACT_CLEAR,  32'sd0,         1,  1'b1, '{32'sd0, 5'd0,  ST_OK,       1'b1}}
        };
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 30;
        foreach (dir_rows[n]) begin
            it.action = dir_rows[n].action;
            it.value  = dir_rows[n].value;
            repeat (dir_rows[n].reps) issue(it, dir_rows[n].typed, dir_rows[n].result);
        end

        // Small pool so that duplicates and matching removes are common.
        value_pool[0] = 32'h80000000;
        value_pool[1] = 32'h7fffffff;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;
        value_pool[4] = $urandom;
        value_pool[5] = $urandom;

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 30 : (ph == 1) ? 51 : 0;
            issued   = 0;
            while (issued < 72) begin
                sel = $urandom_range(99);
                if (sel < 6) begin
                    // fill burst: drive the table towards full
                    it.action = ACT_INSERT;
                    repeat (DEPTH) begin
                        it.value = pick_value();
                        issue(it, 1'b0, '0);
                    end
                    issued += DEPTH;
                end else begin
                    it.action = (sel < 50) ? ACT_INSERT :
                                (sel < 66) ? ACT_READ :
                                (sel < 90) ? ACT_REMOVE : ACT_CLEAR;
                    it.value  = pick_value();
                    issue(it, 1'b0, '0);
                    issued++;
                end
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
